@@ rtl/text_search_case_word_options_assert.svh @@
// Assertion macros shared by the text search checker.
`ifndef TEXT_SEARCH_CASE_WORD_OPTIONS_ASSERT_SVH
`define TEXT_SEARCH_CASE_WORD_OPTIONS_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define TSCWO_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define TSCWO_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tscwo_pkg.sv @@
// Types, constants and character helpers for the text search block.
`timescale 1ns / 1ps
package tscwo_pkg;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int SLOT_W      = 5;
  localparam int LEN_W       = 6;
  localparam int POS_W       = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Request kinds on in_tuser
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_CASE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WHOLE_WORD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BACKWARD   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET     = 3'd4;

  // Control shared by every cell of the text row
  typedef struct packed {
    logic shift;
    logic match_case;
  } cell_ctl_t;

  // Per-cell compare results
  typedef struct packed {
    logic eq_a;
    logic eq_b;
    logic alnum;
  } cell_stat_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    fold_case = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic logic chars_equal(input logic [CHAR_W-1:0] a,
                                       input logic [CHAR_W-1:0] b,
                                       input logic              exact);
    chars_equal = exact ? (a == b) : (fold_case(a) == fold_case(b));
  endfunction

endpackage

@@ rtl/tscwo_cell.sv @@
// One cell of the text row: holds one character, compares it to two pattern bytes.
`timescale 1ns / 1ps
module tscwo_cell (
  input  logic                          clk,
  input  tscwo_pkg::cell_ctl_t          ctl,
  input  logic [tscwo_pkg::CHAR_W-1:0]  char_in,
  input  logic [tscwo_pkg::CHAR_W-1:0]  pat_a,
  input  logic [tscwo_pkg::CHAR_W-1:0]  pat_b,
  output logic [tscwo_pkg::CHAR_W-1:0]  char_out,
  output tscwo_pkg::cell_stat_t         stat
);
  import tscwo_pkg::*;

  logic [CHAR_W-1:0] char_r;

  // take the neighbor's character on each stored text character
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      char_r <= char_in;
    end
  end

  assign char_out = char_r;

  // eq_a: window ending at the previous character, eq_b: window one further on
  assign stat.eq_a  = chars_equal(char_r, pat_a, ctl.match_case);
  assign stat.eq_b  = chars_equal(char_r, pat_b, ctl.match_case);
  assign stat.alnum = is_alnum(char_r);

endmodule

@@ rtl/text_search_case_word_options.sv @@
// Top level of the streaming substring search with case and whole-word options.
//
//  port group | dir | contents
//  in_*       | in  | pattern load or text character request, tlast ends a search
//  out_*      | out | one search result per text request with tlast
//  cfg_*      | in  | register writes, index on cfg_addr
//
// One request is taken every cycle while in_tready is high. Each text character is
// checked against the whole pattern window at once across the cell row, so the row
// compare and the start-position compare set the cycle. The result is registered in
// the output register, or in the skid stage while that is full; in_tready drops only
// while both are full. Synchronous reset, no clearing pass.
`timescale 1ns / 1ps
module text_search_case_word_options #(
  parameter int PATTERN_MAX = 32,
  parameter int TEXT_MAX    = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // slave side
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tscwo_pkg::IN_TDATA_W-1:0]     in_tdata,   // [4:0] pattern_index, [12:5] char_code
  input  logic                                 in_tuser,   // [0] command
  input  logic                                 in_tlast,   // last_char
  // master side
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tscwo_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [15:0] match_position, [16] text_overflow
  output logic                                 out_tuser,  // [0] found
  // configuration
  input  logic                                 cfg_we,
  input  logic [tscwo_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tscwo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tscwo_pkg::*;

  localparam int CW  = $clog2(TEXT_MAX + 1);
  localparam int SW  = (CW > POS_W) ? CW : POS_W;
  localparam int SHW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PFW = PATTERN_MAX * CHAR_W;

  // ---------------- configuration registers ----------------
  logic              match_case_r;
  logic              whole_word_r;
  logic              backward_r;
  logic [LEN_W-1:0]  len_r;
  logic [POS_W-1:0]  offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_case_r <= 1'b1;
      whole_word_r <= 1'b0;
      backward_r   <= 1'b0;
      len_r        <= LEN_W'(1);
      offset_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MATCH_CASE: match_case_r <= cfg_wdata[0];
        CFG_WHOLE_WORD: whole_word_r <= cfg_wdata[0];
        CFG_BACKWARD:   backward_r   <= cfg_wdata[0];
        CFG_PAT_LEN:    len_r        <= cfg_wdata[LEN_W-1:0];
        CFG_OFFSET:     offset_r     <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- request decode ----------------
  logic              in_fire;
  logic              is_text;
  logic              pat_we;
  logic [SLOT_W-1:0] in_slot;
  logic [CHAR_W-1:0] in_char;
  logic              skid_vld_r;

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign is_text   = in_fire && (in_tuser == CMD_TEXT);
  assign pat_we    = in_fire && (in_tuser == CMD_PATTERN);
  assign in_slot   = in_tdata[SLOT_W-1:0];
  assign in_char   = in_tdata[SLOT_W +: CHAR_W];

  // ---------------- search state ----------------
  logic [CW-1:0] count_r, count_nxt;
  logic          have_r, have_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic          ovf_r, ovf_nxt;
  logic          in_range;
  logic          shift_en;

  assign in_range = count_r < CW'(TEXT_MAX);
  assign shift_en = is_text && in_range;

  // ---------------- pattern bank, aligned to the window ----------------
  logic [CHAR_W-1:0] pat_r [PATTERN_MAX];
  logic [PFW-1:0]    pat_rev;
  logic [PFW-1:0]    pat_aligned;
  logic [SHW-1:0]    shamt;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    always_ff @(posedge clk) begin
      if (pat_we && (int'(in_slot) == k)) begin
        pat_r[k] <= in_char;
      end
    end
    assign pat_rev[k*CHAR_W +: CHAR_W] = pat_r[PATTERN_MAX-1-k];
  end

  // chunk j of the aligned bank is pattern[len-1-j]
  assign shamt       = SHW'(PATTERN_MAX - int'(len_r));
  assign pat_aligned = pat_rev >> {shamt, 3'b000};

  // ---------------- text cell row ----------------
  cell_ctl_t         cell_ctl;
  cell_stat_t        stat [PATTERN_MAX];
  logic [CHAR_W-1:0] cell_char [PATTERN_MAX];
  logic [CHAR_W-1:0] bef_r;
  logic [PATTERN_MAX-1:0] eq_a, eq_b, use_a, use_b, sel_last;
  logic [PATTERN_MAX-1:0] t_alnum, t1_alnum, n_alnum;
  logic              c_alnum;
  logic              bef_alnum;

  assign cell_ctl.shift      = shift_en;
  assign cell_ctl.match_case = match_case_r;
  assign c_alnum             = is_alnum(in_char);
  assign bef_alnum           = is_alnum(bef_r);

  // character pushed out of the last cell, needed as the one before a full-length match
  always_ff @(posedge clk) begin
    if (shift_en) begin
      bef_r <= cell_char[PATTERN_MAX-1];
    end
  end

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [CHAR_W-1:0] c_in;
    logic [CHAR_W-1:0] pb;

    if (j == 0) begin : g_head
      assign c_in       = in_char;
      assign n_alnum[j] = c_alnum;
    end else begin : g_body
      assign c_in       = cell_char[j-1];
      assign n_alnum[j] = stat[j-1].alnum;
    end

    if (j < PATTERN_MAX - 1) begin : g_pb
      assign pb          = pat_aligned[(j+1)*CHAR_W +: CHAR_W];
      assign t1_alnum[j] = stat[j+1].alnum;
    end else begin : g_pb_end
      assign pb          = '0;
      assign t1_alnum[j] = bef_alnum;
    end

    tscwo_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .char_in  (c_in),
      .pat_a    (pat_aligned[j*CHAR_W +: CHAR_W]),
      .pat_b    (pb),
      .char_out (cell_char[j]),
      .stat     (stat[j])
    );

    assign eq_a[j]     = stat[j].eq_a;
    assign eq_b[j]     = stat[j].eq_b;
    assign t_alnum[j]  = stat[j].alnum;
    assign use_a[j]    = j < int'(len_r);
    assign use_b[j]    = (j + 1) < int'(len_r);
    assign sel_last[j] = (j + 1) == int'(len_r);
  end

  // ---------------- window checks ----------------
  // A: window ending at the newest stored character, next char is the incoming one
  // B: window ending at the incoming character (last character of the text)
  logic          len_ok;
  logic          eq_c;
  logic          ok_a, ok_b;
  logic          first_t, before_t, first_n;
  logic [SW-1:0] cnt_w, len_w, off_w, start_a, start_b;
  logic          word_a, word_b;
  logic          chk_a, chk_b, hit_a, hit_b;

  assign len_ok = (len_r != '0) && (int'(len_r) <= PATTERN_MAX);
  assign eq_c   = chars_equal(in_char, pat_aligned[CHAR_W-1:0], match_case_r);
  assign ok_a   = len_ok && (&(eq_a | ~use_a));
  assign ok_b   = len_ok && eq_c && (&(eq_b | ~use_b));

  assign first_t  = |(sel_last & t_alnum);
  assign before_t = |(sel_last & t1_alnum);
  assign first_n  = |(sel_last & n_alnum);

  assign cnt_w   = SW'(count_r);
  assign len_w   = SW'(len_r);
  assign off_w   = SW'(offset_r);
  assign start_a = cnt_w - len_w;
  assign start_b = cnt_w + SW'(1) - len_w;

  assign word_a = !whole_word_r ||
                  (first_t && t_alnum[0] && !((start_a != '0) && before_t) &&
                   !(in_range && c_alnum));
  assign word_b = !whole_word_r ||
                  (first_n && c_alnum && !((start_b != '0) && first_t));

  assign chk_a = is_text && (in_range || in_tlast) && (cnt_w >= len_w) && ok_a && word_a;
  assign chk_b = is_text && in_range && in_tlast && ((cnt_w + SW'(1)) >= len_w) &&
                 ok_b && word_b;
  assign hit_a = chk_a && (backward_r ? (start_a <= off_w) : (start_a >= off_w));
  assign hit_b = chk_b && (backward_r ? (start_b <= off_w) : (start_b >= off_w));

  // ---------------- match bookkeeping ----------------
  logic             have_upd;
  logic [SW-1:0]    best_upd;
  logic             ovf_upd;
  logic             res_vld;
  logic             res_found;
  logic [POS_W-1:0] res_pos;
  logic             res_ovf;

  always_comb begin
    have_upd = have_r;
    best_upd = best_r;
    if (backward_r) begin
      if (hit_b) begin
        have_upd = 1'b1;
        best_upd = start_b;
      end else if (hit_a) begin
        have_upd = 1'b1;
        best_upd = start_a;
      end
    end else if (!have_r) begin
      if (hit_a) begin
        have_upd = 1'b1;
        best_upd = start_a;
      end else if (hit_b) begin
        have_upd = 1'b1;
        best_upd = start_b;
      end
    end
    ovf_upd   = ovf_r || (is_text && !in_range);
    res_vld   = is_text && in_tlast;
    res_found = have_upd;
    res_pos   = have_upd ? best_upd[POS_W-1:0] : '0;
    res_ovf   = ovf_upd;

    count_nxt = shift_en ? (count_r + CW'(1)) : count_r;
    have_nxt  = have_upd;
    best_nxt  = best_upd;
    ovf_nxt   = ovf_upd;
    if (res_vld) begin
      count_nxt = '0;
      have_nxt  = 1'b0;
      best_nxt  = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      have_r  <= 1'b0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      have_r  <= have_nxt;
      best_r  <= best_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // ---------------- output register and skid stage ----------------
  logic             out_vld_r, out_vld_nxt;
  logic             skid_vld_nxt;
  logic             out_found_r, out_found_nxt, skid_found_r, skid_found_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt, skid_pos_r, skid_pos_nxt;
  logic             out_ovf_r, out_ovf_nxt, skid_ovf_r, skid_ovf_nxt;
  logic             out_take;

  assign out_take = out_vld_r && out_tready;

  always_comb begin
    out_vld_nxt    = out_vld_r;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_ovf_nxt    = out_ovf_r;
    skid_vld_nxt   = skid_vld_r;
    skid_found_nxt = skid_found_r;
    skid_pos_nxt   = skid_pos_r;
    skid_ovf_nxt   = skid_ovf_r;
    if (skid_vld_r) begin
      // input is held off; drain the skid into the output register
      if (out_take) begin
        out_found_nxt = skid_found_r;
        out_pos_nxt   = skid_pos_r;
        out_ovf_nxt   = skid_ovf_r;
        skid_vld_nxt  = 1'b0;
      end
    end else if (res_vld) begin
      if (!out_vld_r || out_take) begin
        out_vld_nxt   = 1'b1;
        out_found_nxt = res_found;
        out_pos_nxt   = res_pos;
        out_ovf_nxt   = res_ovf;
      end else begin
        skid_vld_nxt   = 1'b1;
        skid_found_nxt = res_found;
        skid_pos_nxt   = res_pos;
        skid_ovf_nxt   = res_ovf;
      end
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_pos_r    <= out_pos_nxt;
    out_ovf_r    <= out_ovf_nxt;
    skid_found_r <= skid_found_nxt;
    skid_pos_r   <= skid_pos_nxt;
    skid_ovf_r   <= skid_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {(OUT_TDATA_W - POS_W - 1)'(0), out_ovf_r, out_pos_r};

endmodule

@@ rtl/tscwo_checker.sv @@
// Port-level checks for the text search block, bound to the top level.
`timescale 1ns / 1ps
`include "text_search_case_word_options_assert.svh"
module tscwo_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tuser,
  input logic                                in_tlast,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [tscwo_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                                out_tuser
);
  import tscwo_pkg::*;

  // a result waiting on the sink keeps its contents
  `TSCWO_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // a new result only follows a final text character request
  `TSCWO_ASSERT_IMP(a_out_cause, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tlast && (in_tuser == CMD_TEXT)), "result without a final text character")

  // no match means position zero
  `TSCWO_ASSERT_IMP(a_pos_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[POS_W-1:0] == '0, "position set without a match")

  // nothing is presented right after reset
  `TSCWO_ASSERT_IMP(a_reset_idle, clk, rst_n, $past(!rst_n), !out_tvalid, "result right after reset")

endmodule

bind text_search_case_word_options tscwo_checker u_tscwo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/sv/match_result_checker.sv @@
// Checker for the text search block: predicts search results and compares them.
`timescale 1ns / 1ps
module match_result_checker #(
  parameter int PATTERN_MAX = 32,
  parameter int TEXT_MAX    = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [tscwo_pkg::IN_TDATA_W-1:0]    in_tdata,   // [4:0] pattern_index, [12:5] char_code
  input  logic                                in_tuser,   // [0] command
  input  logic                                in_tlast,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [tscwo_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [15:0] match_position, [16] text_overflow
  input  logic                                out_tuser,  // [0] found
  input  logic                                cfg_we,
  input  logic [tscwo_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tscwo_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output int unsigned                         errors,
  output int unsigned                         outstanding
);
  import tscwo_pkg::*;

  localparam int HIST_N = PATTERN_MAX + 2;

  typedef struct packed {
    logic        found;
    logic [15:0] pos;
    logic        ovf;
  } search_result_t;

  // register copies
  logic        opt_case;
  logic        opt_word;
  logic        opt_back;
  logic [5:0]  opt_len;
  logic [15:0] opt_off;

  // search state
  logic [7:0]  pat_mem [PATTERN_MAX];
  logic [7:0]  hist [HIST_N];
  int unsigned char_cnt;
  bit          hit;
  int unsigned best_pos;
  bit          ovf;

  search_result_t results_due [$];
  int unsigned    fails;

  function automatic bit alnum_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] lower_char(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic void clear_search();
    foreach (hist[i]) hist[i] = 8'h00;
    char_cnt = 0;
    hit      = 0;
    best_pos = 0;
    ovf      = 0;
  endfunction

  // Judge the alignment whose last character sits at end_pos.
  function automatic void try_alignment(int unsigned end_pos, bit has_next,
                                        logic [7:0] next_ch);
    int unsigned start;
    logic [7:0]  a;
    logic [7:0]  b;
    if (opt_len == 0 || opt_len > PATTERN_MAX) return;
    if (end_pos + 1 < opt_len) return;
    start = end_pos + 1 - opt_len;
    for (int i = 0; i < opt_len; i++) begin
      a = hist[(start + i) % HIST_N];
      b = pat_mem[i];
      if (!opt_case) begin
        a = lower_char(a);
        b = lower_char(b);
      end
      if (a != b) return;
    end
    if (opt_word) begin
      if (!alnum_char(hist[start % HIST_N]) || !alnum_char(hist[end_pos % HIST_N])) return;
      if (start > 0 && alnum_char(hist[(start - 1) % HIST_N])) return;
      if (has_next && alnum_char(next_ch)) return;
    end
    if (opt_back) begin
      if (start <= opt_off) begin
        hit      = 1;
        best_pos = start;
      end
    end else if (!hit && start >= opt_off) begin
      hit      = 1;
      best_pos = start;
    end
  endfunction

  // One accepted request: pattern load or text character.
  function automatic void take_request(logic cmd, logic [4:0] slot, logic [7:0] ch,
                                       logic last);
    search_result_t r;
    if (cmd == CMD_PATTERN) begin
      pat_mem[slot] = ch;
      return;
    end
    if (char_cnt < TEXT_MAX) begin
      hist[char_cnt % HIST_N] = ch;
      if (char_cnt > 0) try_alignment(char_cnt - 1, 1, ch);
      char_cnt++;
    end else begin
      ovf = 1;
    end
    if (!last) return;
    if (char_cnt > 0) try_alignment(char_cnt - 1, 0, 8'h00);
    r.found = hit;
    r.pos   = hit ? best_pos[15:0] : 16'h0000;
    r.ovf   = ovf;
    results_due.push_back(r);
    clear_search();
  endfunction

  function automatic void check_result();
    search_result_t e;
    if (results_due.size() == 0) begin
      fails++;
      $display("%0t: unexpected result found=%0d pos=%0d overflow=%0d", $time,
               out_tuser, out_tdata[15:0], out_tdata[16]);
      return;
    end
    e = results_due.pop_front();
    if (out_tuser !== e.found) begin
      fails++;
      $display("%0t: found expected %0d actual %0d", $time, e.found, out_tuser);
    end
    if (out_tdata[15:0] !== e.pos) begin
      fails++;
      $display("%0t: match_position expected %0d actual %0d", $time, e.pos, out_tdata[15:0]);
    end
    if (out_tdata[16] !== e.ovf) begin
      fails++;
      $display("%0t: text_overflow expected %0d actual %0d", $time, e.ovf, out_tdata[16]);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      opt_case = 1'b1;
      opt_word = 1'b0;
      opt_back = 1'b0;
      opt_len  = 6'd1;
      opt_off  = 16'h0000;
      foreach (pat_mem[i]) pat_mem[i] = 8'h00;
      clear_search();
      results_due.delete();
      fails = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MATCH_CASE: opt_case = cfg_wdata[0];
          CFG_WHOLE_WORD: opt_word = cfg_wdata[0];
          CFG_BACKWARD:   opt_back = cfg_wdata[0];
          CFG_PAT_LEN:    opt_len  = cfg_wdata[5:0];
          CFG_OFFSET:     opt_off  = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        take_request(in_tuser, in_tdata[4:0], in_tdata[12:5], in_tlast);
      if (out_tvalid && out_tready)
        check_result();
    end
    errors      <= fails;
    outstanding <= results_due.size();
  end

endmodule

@@ tb/sv/tb_text_search_case_word_options.sv @@
// Testbench top for the text search block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_text_search_case_word_options;
  import tscwo_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [4:0] pattern_index, [12:5] char_code
  logic                   in_tuser = 1'b0; // [0] command
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [15:0] match_position, [16] text_overflow
  logic                   out_tuser;       // [0] found
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  int unsigned            errors;
  int unsigned            outstanding;

  bit          calm = 1'b0;   // no idling on either side while set
  int unsigned fed;           // requests sent in the random part
  int unsigned searches;
  int unsigned pat_len = 1;
  logic [7:0]  pat_now [32];
  logic [7:0]  text_buf [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_search_case_word_options u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  match_result_checker u_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .errors, .outstanding
  );

  // result side back-pressure
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 26);

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // One request; valid stays high afterwards so back-to-back requests need no gap.
  task automatic push_req(logic cmd, logic [4:0] slot, logic [7:0] ch, logic last);
    while (!calm && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, ch, slot};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fed++;
  endtask

  // Drain every expected result and let the pipeline settle.
  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PAT_LEN) pat_len = val[5:0];
  endtask

  task automatic load_slot(int unsigned i, logic [7:0] ch, logic last);
    pat_now[i] = ch;
    push_req(CMD_PATTERN, 5'(i), ch, last);
  endtask

  // Sends text_buf as one search, last flag on the final character.
  task automatic run_text(bit edits);
    for (int i = 0; i < text_buf.size(); i++) begin
      // occasional pattern rewrite in the middle of a search
      if (edits && pat_len >= 1 && pat_len <= 32 && $urandom_range(99) < 3)
        load_slot($urandom_range(pat_len - 1), word_char(), 1'b0);
      push_req(CMD_TEXT, 5'($urandom), text_buf[i], i == text_buf.size() - 1);
    end
    searches++;
  endtask

  task automatic text_of(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    int unsigned k;
    k = $urandom_range(61);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 36) return 8'h41 + 8'(k - 10);
    return 8'h61 + 8'(k - 36);
  endfunction

  function automatic logic [7:0] gap_char();
    case ($urandom_range(5))
      0: return 8'h20;
      1: return 8'h2C;
      2: return 8'h2E;
      3: return 8'h2D;
      4: return 8'h00;
      default: return 8'hA0;
    endcase
  endfunction

  function automatic logic [7:0] pattern_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return word_char();
    if (r < 85) return gap_char();
    return 8'($urandom_range(255));
  endfunction

  // letters sometimes swap case so folding gets exercised
  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
        $urandom_range(99) < 30)
      return c ^ 8'h20;
    return c;
  endfunction

  // Text made of pattern copies, separators, word characters and raw bytes.
  task automatic build_text();
    int unsigned goal;
    int unsigned r;
    text_buf.delete();
    goal = ($urandom_range(9) == 0) ? $urandom_range(41, 90) : $urandom_range(1, 40);
    while (text_buf.size() < goal) begin
      r = $urandom_range(99);
      if (r < 40 && pat_len >= 1 && pat_len <= 32) begin
        for (int i = 0; i < pat_len; i++) text_buf.push_back(flip_case(pat_now[i]));
      end else if (r < 65) begin
        text_buf.push_back(gap_char());
      end else if (r < 90) begin
        text_buf.push_back(word_char());
      end else begin
        text_buf.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  function automatic logic [15:0] pick_offset(int unsigned span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(span));
    if (r < 65) return 16'h0000;
    if (r < 80) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  initial begin
    string       w;
    int unsigned len;
    int unsigned phase;
    w = "word";
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: exact, any word, forward, one character; last flag on a load
    load_slot(0, "a", 1'b1);
    text_of("xa");
    run_text(0);

    // folded case, whole word, backward with the highest limit
    go_idle();
    set_reg(CFG_MATCH_CASE, 16'd0);
    set_reg(CFG_WHOLE_WORD, 16'd1);
    set_reg(CFG_BACKWARD, 16'd1);
    set_reg(CFG_PAT_LEN, 16'd3);
    set_reg(CFG_OFFSET, 16'hFFFF);
    load_slot(0, "C", 1'b0);
    load_slot(1, "a", 1'b0);
    load_slot(2, "t", 1'b0);
    text_of("cats,CAT");
    run_text(0);

    // zero length and lengths beyond the pattern store never match
    go_idle();
    set_reg(CFG_PAT_LEN, 16'd0);
    text_of("ab");
    run_text(0);
    go_idle();
    set_reg(CFG_PAT_LEN, 16'd63);
    text_of("Ca");
    run_text(0);

    // extreme character codes, exact compare
    go_idle();
    set_reg(CFG_MATCH_CASE, 16'd1);
    set_reg(CFG_WHOLE_WORD, 16'd0);
    set_reg(CFG_BACKWARD, 16'd0);
    set_reg(CFG_PAT_LEN, 16'd2);
    set_reg(CFG_OFFSET, 16'd0);
    load_slot(0, 8'h00, 1'b0);
    load_slot(1, 8'hFF, 1'b0);
    text_buf.delete();
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    run_text(0);

    // text past the position limit: match ends at the last kept character
    go_idle();
    set_reg(CFG_PAT_LEN, 16'd4);
    set_reg(CFG_OFFSET, 16'd65530);
    for (int i = 0; i < 4; i++) load_slot(i, w[i], 1'b0);
    text_buf.delete();
    for (int i = 0; i < 65540; i++) begin
      if (i >= 65532 && i < 65536) text_buf.push_back(w[i - 65532]);
      else text_buf.push_back($urandom_range(1) ? "a" : "b");
    end
    run_text(0);

    // random phases: settings, pattern, then a few searches
    fed = 0;
    searches = 0;
    phase = 0;
    while (fed < 1300 || searches < 40) begin
      calm = (phase >= 6 && phase < 10);
      go_idle();
      set_reg(CFG_MATCH_CASE, 16'($urandom_range(1)));
      set_reg(CFG_WHOLE_WORD, 16'($urandom_range(1)));
      set_reg(CFG_BACKWARD, 16'($urandom_range(1)));
      case ($urandom_range(99)) inside
        [0:3]:   len = 0;
        [4:7]:   len = $urandom_range(33, 63);
        [8:17]:  len = 32;
        [18:29]: len = $urandom_range(9, 31);
        default: len = $urandom_range(1, 8);
      endcase
      set_reg(CFG_PAT_LEN, 16'(len));
      for (int i = 0; i < len && i < 32; i++)
        load_slot(i, pattern_char(), $urandom_range(9) == 0);
      repeat ($urandom_range(1, 4)) begin
        build_text();
        go_idle();
        set_reg(CFG_OFFSET, pick_offset(text_buf.size()));
        run_text(1);
      end
      phase++;
    end
    calm = 1'b0;

    go_idle();
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ text_search_case_word_options.f @@
+incdir+rtl
rtl/tscwo_pkg.sv
rtl/tscwo_cell.sv
rtl/text_search_case_word_options.sv
rtl/tscwo_checker.sv
tb/sv/match_result_checker.sv
tb/sv/tb_text_search_case_word_options.sv
